// ===== rtl/core/mdle_pkg.sv =====
// ----------------------------------------------------------------------------
// mdle_pkg
// Shared types, constants and marker tables for the line extractor.
// ----------------------------------------------------------------------------
package mdle_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_NEST    = 255;
    localparam int DEPTH_W     = $clog2(MAX_NEST + 1);
    localparam int WORD_MAX    = 10;
    localparam int WLEN_W      = $clog2(WORD_MAX + 1);
    localparam int N_MARK      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Marker sets: bits 0 and 2 begin, bits 1 and 3 end
    localparam logic [N_MARK-1:0] ALL_LIVE  = 4'hF;
    localparam logic [N_MARK-1:0] BEGIN_SET = 4'h5;
    localparam logic [N_MARK-1:0] END_SET   = 4'hA;

    localparam logic [BYTE_W-1:0] MARKER_TEXT [N_MARK][WORD_MAX] = '{
        '{"c", "#", "b", "e", "g", "i", "n", "d", "o", "c"},
        '{"c", "#", "e", "n", "d", "d", "o", "c", 8'h00, 8'h00},
        '{"!", "#", "b", "e", "g", "i", "n", "d", "o", "c"},
        '{"!", "#", "e", "n", "d", "d", "o", "c", 8'h00, 8'h00}
    };
    localparam logic [WLEN_W-1:0] MARKER_LEN [N_MARK] = '{
        WLEN_W'(10), WLEN_W'(8), WLEN_W'(10), WLEN_W'(8)
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_UNCLOSED  = 2'd2
    } t_status;

    // Line parser phase, one-hot
    typedef enum logic [2:0] {
        PH_WORD = 3'b001,
        PH_COPY = 3'b010,
        PH_SKIP = 3'b100
    } t_phase;

    // One queued command: emit wlen buffered bytes, then one final result
    typedef struct packed {
        logic [WORD_MAX-1:0][BYTE_W-1:0] word;
        logic [WLEN_W-1:0]               wlen;
        logic                            has_byte;
        logic [BYTE_W-1:0]               data;
        t_status                         status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_white(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
        return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
    endfunction

endpackage

// ===== rtl/core/mdle_in_if.sv =====
// ----------------------------------------------------------------------------
// mdle_in_if
// Input channel: one text byte or an end-of-input beat.
// ----------------------------------------------------------------------------
interface mdle_in_if
    import mdle_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;

    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

// ===== rtl/core/mdle_out_if.sv =====
// ----------------------------------------------------------------------------
// mdle_out_if
// Output channel: one extracted byte (or empty beat) with status and last.
// ----------------------------------------------------------------------------
interface mdle_out_if
    import mdle_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, out_byte, byte_valid, status, last, input ready);
    modport sink   (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

// ===== rtl/core/mdle_front.sv =====
// ----------------------------------------------------------------------------
// mdle_front
// Accepts bytes, tracks the first word of each line, matches markers and
// nesting depth, and posts one output command per accepted beat.
// ----------------------------------------------------------------------------
module mdle_front
    import mdle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdle_in_if.sink    i_in,
    input  t_q_status  i_qstat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [DEPTH_W-1:0]              r_depth, n_depth;
    t_status                         r_err, n_err;
    t_phase                          r_phase, n_phase;
    logic [WLEN_W-1:0]               r_wlen, n_wlen;
    logic [N_MARK-1:0]               r_cand, n_cand;
    logic [WORD_MAX-1:0][BYTE_W-1:0] r_word;

    logic                accept;
    logic                wr_buf;
    logic [BYTE_W-1:0]   b;
    logic [N_MARK-1:0]   hit;
    logic [N_MARK-1:0]   live;
    logic [WLEN_W-1:0]   tidx;
    logic                is_begin;
    logic                is_end;
    logic                is_plain;
    logic [DEPTH_W-1:0]  j_depth;
    t_status             j_err;
    t_cmd                cmd;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign o_push     = accept;
    assign o_cmd      = cmd;

    // Judge the buffered first word against the surviving markers
    always_comb begin
        for (int k = 0; k < N_MARK; k++) begin
            hit[k] = r_cand[k] && (r_wlen == MARKER_LEN[k]);
        end
        is_begin = |(hit & BEGIN_SET);
        is_end   = !is_begin && |(hit & END_SET);
        is_plain = !is_begin && !is_end;
        j_depth  = r_depth;
        j_err    = r_err;
        if (is_begin) begin
            if (r_depth != DEPTH_W'(MAX_NEST)) begin
                j_depth = r_depth + 1'b1;
            end
        end else if (is_end) begin
            if (r_depth == '0) begin
                if (r_err == ST_OK) begin
                    j_err = ST_UNMATCHED;
                end
            end else begin
                j_depth = r_depth - 1'b1;
            end
        end
    end

    // Markers still matching after the current byte
    always_comb begin
        tidx = (r_wlen < WLEN_W'(WORD_MAX)) ? r_wlen : '0;
        for (int k = 0; k < N_MARK; k++) begin
            live[k] = r_cand[k] && (r_wlen < MARKER_LEN[k])
                      && (MARKER_TEXT[k][tidx] == fold(b));
        end
    end

    // Next state and output command
    always_comb begin
        n_depth      = r_depth;
        n_err        = r_err;
        n_phase      = r_phase;
        n_wlen       = r_wlen;
        n_cand       = r_cand;
        wr_buf       = 1'b0;
        cmd.word     = r_word;
        cmd.wlen     = '0;
        cmd.has_byte = 1'b0;
        cmd.data     = '0;

        if (i_in.end_of_input) begin
            unique case (r_phase)
                PH_WORD: begin
                    if (r_wlen != '0) begin
                        n_depth = j_depth;
                        n_err   = j_err;
                        if (is_plain && (r_depth != '0)) begin
                            cmd.wlen     = r_wlen;
                            cmd.has_byte = 1'b1;
                            cmd.data     = CH_LF;
                        end
                    end
                end
                PH_COPY: begin
                    cmd.has_byte = 1'b1;
                    cmd.data     = CH_LF;
                end
                PH_SKIP: begin
                end
                default: begin
                end
            endcase
            if ((n_depth != '0) && (n_err == ST_OK)) begin
                n_err = ST_UNCLOSED;
            end
            n_phase = PH_WORD;
            n_wlen  = '0;
            n_cand  = ALL_LIVE;
        end else begin
            unique case (r_phase)
                PH_COPY: begin
                    cmd.has_byte = 1'b1;
                    cmd.data     = b;
                    if (b == CH_LF) begin
                        n_phase = PH_WORD;
                        n_wlen  = '0;
                        n_cand  = ALL_LIVE;
                    end
                end
                PH_SKIP: begin
                    if (b == CH_LF) begin
                        n_phase = PH_WORD;
                        n_wlen  = '0;
                        n_cand  = ALL_LIVE;
                    end
                end
                PH_WORD: begin
                    if (is_white(b)) begin
                        // first word ends here
                        n_depth = j_depth;
                        n_err   = j_err;
                        n_wlen  = '0;
                        if (is_plain && (r_depth != '0)) begin
                            cmd.wlen     = r_wlen;
                            cmd.has_byte = 1'b1;
                            cmd.data     = b;
                            n_phase      = (b == CH_LF) ? PH_WORD : PH_COPY;
                        end else begin
                            n_phase = (b == CH_LF) ? PH_WORD : PH_SKIP;
                        end
                        if (b == CH_LF) begin
                            n_cand = ALL_LIVE;
                        end
                    end else if ((live != '0) && (r_wlen < WLEN_W'(WORD_MAX))) begin
                        wr_buf = 1'b1;
                        n_wlen = r_wlen + 1'b1;
                        n_cand = live;
                    end else begin
                        // no marker possible: copy or drop the line
                        if (r_depth != '0) begin
                            cmd.wlen     = r_wlen;
                            cmd.has_byte = 1'b1;
                            cmd.data     = b;
                            n_phase      = PH_COPY;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                        n_wlen = '0;
                        n_cand = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        cmd.status = n_err;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= ST_OK;
            r_phase <= PH_WORD;
            r_wlen  <= '0;
            r_cand  <= ALL_LIVE;
        end else if (accept) begin
            r_depth <= n_depth;
            r_err   <= n_err;
            r_phase <= n_phase;
            r_wlen  <= n_wlen;
            r_cand  <= n_cand;
        end
    end

    // Word buffer, no reset
    always_ff @(posedge i_clk) begin
        if (accept && wr_buf) begin
            r_word[r_wlen] <= b;
        end
    end

endmodule

// ===== rtl/core/mdle_queue.sv =====
// ----------------------------------------------------------------------------
// mdle_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mdle_queue
    import mdle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output t_q_status  o_stat
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Pointer wrap
    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/mdle_back.sv =====
// ----------------------------------------------------------------------------
// mdle_back
// Unrolls each queued command into output beats: buffered word bytes
// first, then the final beat, through a registered output stage.
// ----------------------------------------------------------------------------
module mdle_back
    import mdle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_qstat,
    output logic       o_pop,
    mdle_out_if.source o_out
);

    logic [WLEN_W-1:0]  r_idx;
    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_bv;
    t_status            r_status;
    logic               r_last;

    logic               load;
    logic               in_word;
    logic               is_last;
    logic [WLEN_W-1:0]  widx;

    assign load    = !r_valid || o_out.ready;
    assign in_word = (r_idx < i_head.wlen);
    assign is_last = (r_idx == i_head.wlen);
    assign widx    = (r_idx < WLEN_W'(WORD_MAX)) ? r_idx : '0;
    assign o_pop   = load && !i_qstat.empty && is_last;

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.byte_valid = r_bv;
    assign o_out.status     = r_status;
    assign o_out.last       = r_last;

    // Beat index within the head command, and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load && !i_qstat.empty) begin
            r_byte   <= in_word ? i_head.word[widx] : i_head.data;
            r_bv     <= in_word ? 1'b1 : i_head.has_byte;
            r_status <= i_head.status;
            r_last   <= is_last;
        end
    end

endmodule

// ===== rtl/core/marker_delimited_line_extractor.sv =====
// ----------------------------------------------------------------------------
// marker_delimited_line_extractor
// Copies text lines between begin and end document markers to the output.
// ----------------------------------------------------------------------------
// Path: the first result of a beat passes through the command queue and
// then the output register before it leaves the block.
// Throughput: one input beat per cycle while the queue is not full; a beat
// may yield up to 11 output results, bursts absorbed by a 4-entry queue.
// Reset: synchronous, active low; depth 0, status ok, parser at line start.
module marker_delimited_line_extractor
    import mdle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdle_in_if.sink    i_in,
    mdle_out_if.source o_out
);

    logic       push;
    logic       pop;
    t_cmd       cmd;
    t_cmd       head;
    t_q_status  qstat;

    // Byte classification and marker tracking
    mdle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // Decoupling queue
    mdle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Output sequencing
    mdle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/marker_delimited_line_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_delimited_line_extractor_test
// Self-checking bench for the line extractor. A directed script runs first,
// then random marker, text and noise lines, then a closing stretch of random
// lines with no idling on either side. Every input beat goes through a line
// predictor, and each output beat is compared with the oldest predicted beat.
// ----------------------------------------------------------------------------
module marker_delimited_line_extractor_test
    import mdle_pkg::*;
;

    localparam int DIR_N      = 30;
    localparam int N_RANDOM   = 400;
    localparam int N_CALM     = 50;
    localparam int LONG_HOLD  = 100;
    localparam int DRAIN      = 20;
    localparam int LIMIT      = 400000;

    // One output beat as the predictor sees it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              bvalid;
        t_status           status;
        logic              last;
    } t_beat;

    // One row of the directed script; want is used only when typed is set
    typedef struct packed {
        logic              eoi;
        logic [BYTE_W-1:0] chr;
        logic              typed;
        t_beat             want;
    } t_row;

    typedef enum {WK_PLAIN, WK_BEGIN, WK_END} t_word_kind;

    localparam t_beat NO_BEAT   = '0;
    localparam t_beat EMPTY_OK  = '{8'h00, 1'b0, ST_OK, 1'b1};
    localparam t_beat EMPTY_UNM = '{8'h00, 1'b0, ST_UNMATCHED, 1'b1};

    localparam t_row SCRIPT [DIR_N] = '{
        // plain word at depth zero, then end of input at line start
        '{1'b0, "x",   1'b1, EMPTY_OK},
        '{1'b0, CH_LF, 1'b1, EMPTY_OK},
        '{1'b1, 8'hFF, 1'b1, EMPTY_OK},
        // end marker with no region open, mixed case
        '{1'b0, "!",   1'b0, NO_BEAT},
        '{1'b0, "#",   1'b0, NO_BEAT},
        '{1'b0, "E",   1'b0, NO_BEAT},
        '{1'b0, "n",   1'b0, NO_BEAT},
        '{1'b0, "D",   1'b0, NO_BEAT},
        '{1'b0, "d",   1'b0, NO_BEAT},
        '{1'b0, "O",   1'b0, NO_BEAT},
        '{1'b0, "c",   1'b0, NO_BEAT},
        '{1'b0, CH_LF, 1'b1, EMPTY_UNM},
        // upper-case begin marker, closed by a space
        '{1'b0, "C",   1'b0, NO_BEAT},
        '{1'b0, "#",   1'b0, NO_BEAT},
        '{1'b0, "B",   1'b0, NO_BEAT},
        '{1'b0, "E",   1'b0, NO_BEAT},
        '{1'b0, "G",   1'b0, NO_BEAT},
        '{1'b0, "I",   1'b0, NO_BEAT},
        '{1'b0, "N",   1'b0, NO_BEAT},
        '{1'b0, "D",   1'b0, NO_BEAT},
        '{1'b0, "O",   1'b0, NO_BEAT},
        '{1'b0, "C",   1'b0, NO_BEAT},
        '{1'b0, " ",   1'b0, NO_BEAT},
        '{1'b0, CH_LF, 1'b0, NO_BEAT},
        // copied line: marker prefix broken by a plain byte, extreme bytes
        '{1'b0, "c",   1'b0, NO_BEAT},
        '{1'b0, "x",   1'b0, NO_BEAT},
        '{1'b0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 8'hFF, 1'b0, NO_BEAT},
        '{1'b0, CH_LF, 1'b0, NO_BEAT},
        // region still open at end, earlier error is kept
        '{1'b1, 8'h00, 1'b1, EMPTY_UNM}
    };

    localparam logic [BYTE_W-1:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    logic i_clk = 1'b0;
    logic i_rst_n;

    mdle_in_if  in_ch ();
    mdle_out_if out_ch ();

    marker_delimited_line_extractor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    int                depth;
    t_phase            phase;
    logic [BYTE_W-1:0] word_q [WORD_MAX];
    int                wlen;
    logic [N_MARK-1:0] cands;
    t_status           err;

    // Predicted beats waiting for the block
    t_beat pending_beats [$];

    int mismatches   = 0;
    int results_seen = 0;
    int sent         = 0;
    int cycles       = 0;
    int src_idle_pct = 0;
    bit calm         = 1'b0;

    // ------------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------------
    function automatic logic blank_char(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void restart_line();
        phase = PH_WORD;
        wlen  = 0;
        cands = ALL_LIVE;
    endfunction

    // Classify the finished first word and apply its effect on depth/status
    function automatic t_word_kind judge_first_word();
        logic [N_MARK-1:0] hit;
        hit = '0;
        for (int k = 0; k < N_MARK; k++)
            if (cands[k] && wlen == int'(MARKER_LEN[k]))
                hit[k] = 1'b1;
        if (|(hit & BEGIN_SET)) begin
            if (depth < MAX_NEST)
                depth++;
            return WK_BEGIN;
        end
        if (|(hit & END_SET)) begin
            if (depth == 0) begin
                if (err == ST_OK)
                    err = ST_UNMATCHED;
            end else begin
                depth--;
            end
            return WK_END;
        end
        return WK_PLAIN;
    endfunction

    function automatic void extract_step(input logic eoi, input logic [BYTE_W-1:0] b,
                                         output t_beat res [$]);
        logic [BYTE_W-1:0] emitted [$];
        logic [N_MARK-1:0] live;
        logic [BYTE_W-1:0] lc;
        t_beat             r;
        res = {};
        if (eoi) begin
            if (phase == PH_WORD) begin
                if (wlen > 0 && judge_first_word() == WK_PLAIN && depth > 0) begin
                    for (int i = 0; i < wlen; i++)
                        emitted.push_back(word_q[i]);
                    emitted.push_back(CH_LF);
                end
            end else if (phase == PH_COPY) begin
                emitted.push_back(CH_LF);
            end
            if (depth != 0 && err == ST_OK)
                err = ST_UNCLOSED;
            restart_line();
        end else if (phase == PH_COPY) begin
            emitted.push_back(b);
            if (b == CH_LF)
                restart_line();
        end else if (phase == PH_SKIP) begin
            if (b == CH_LF)
                restart_line();
        end else if (blank_char(b)) begin
            // first word ended by whitespace
            if (judge_first_word() == WK_PLAIN && depth > 0) begin
                for (int i = 0; i < wlen; i++)
                    emitted.push_back(word_q[i]);
                emitted.push_back(b);
                if (b == CH_LF) begin
                    restart_line();
                end else begin
                    phase = PH_COPY;
                    wlen  = 0;
                end
            end else if (b == CH_LF) begin
                restart_line();
            end else begin
                phase = PH_SKIP;
                wlen  = 0;
            end
        end else begin
            // still inside the first word: narrow the marker candidates
            lc   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            live = '0;
            for (int k = 0; k < N_MARK; k++)
                if (cands[k] && wlen < int'(MARKER_LEN[k]) && MARKER_TEXT[k][wlen] == lc)
                    live[k] = 1'b1;
            if (live != '0 && wlen < WORD_MAX) begin
                word_q[wlen] = b;
                wlen++;
                cands = live;
            end else begin
                if (depth > 0) begin
                    for (int i = 0; i < wlen; i++)
                        emitted.push_back(word_q[i]);
                    emitted.push_back(b);
                    phase = PH_COPY;
                end else begin
                    phase = PH_SKIP;
                end
                wlen  = 0;
                cands = '0;
            end
        end

        if (emitted.size() == 0) begin
            res.push_back('{8'h00, 1'b0, err, 1'b1});
        end else begin
            foreach (emitted[i]) begin
                r = '{emitted[i], 1'b1, err, (i == emitted.size() - 1)};
                res.push_back(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic eoi, input logic [BYTE_W-1:0] chr,
                             input logic typed = 1'b0, input t_beat want = NO_BEAT);
        t_beat res [$];
        if (!calm && src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= chr;
        in_ch.end_of_input <= eoi;
        extract_step(eoi, chr, res);
        if (typed)
            pending_beats.push_back(want);
        else
            foreach (res[i])
                pending_beats.push_back(res[i]);
        sent++;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Hold the sender until every predicted beat has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] text_byte();
        int r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(9);
        if (r < 6)
            return BYTE_W'($urandom_range(8'h21, 8'h7E));
        if (r < 8)
            return BLANKS[$urandom_range(1) ? 0 : $urandom_range(3, 5)];
        b = BYTE_W'($urandom_range(255));
        return (b == CH_LF) ? 8'h0B : b;
    endfunction

    // First n bytes of marker k, each letter in random case
    task automatic send_marker(input int k, input int n);
        logic [BYTE_W-1:0] ch;
        for (int i = 0; i < n; i++) begin
            ch = MARKER_TEXT[k][i];
            if (ch >= "a" && ch <= "z" && $urandom_range(1))
                ch = ch - 8'd32;
            send_beat(1'b0, ch);
        end
    endtask

    task automatic end_line();
        if ($urandom_range(11) == 0)
            send_beat(1'b1, BYTE_W'($urandom_range(255)));
        else
            send_beat(1'b0, CH_LF);
    endtask

    task automatic send_text(input int n);
        for (int i = 0; i < n; i++)
            send_beat(1'b0, text_byte());
    endtask

    // Rest of a line after its first word: separator, text, line end
    task automatic finish_after_word();
        logic [BYTE_W-1:0] sep;
        sep = BLANKS[$urandom_range(5)];
        if (sep == CH_LF) begin
            send_beat(1'b0, CH_LF);
        end else begin
            send_beat(1'b0, sep);
            send_text($urandom_range(0, 6));
            end_line();
        end
    endtask

    task automatic send_line();
        int kind;
        int k;
        kind = $urandom_range(99);
        if (kind < 25) begin
            // begin marker
            k = $urandom_range(1) ? 2 : 0;
            send_marker(k, int'(MARKER_LEN[k]));
            finish_after_word();
        end else if (kind < 45 && (depth > 0 || $urandom_range(5) == 0)) begin
            // end marker
            k = $urandom_range(1) ? 3 : 1;
            send_marker(k, int'(MARKER_LEN[k]));
            finish_after_word();
        end else if (kind < 60) begin
            // marker prefix broken by a stray byte, up to a full word
            k = $urandom_range(3);
            send_marker(k, $urandom_range(1, int'(MARKER_LEN[k])));
            send_beat(1'b0, BYTE_W'($urandom_range(8'h21, 8'h7E)));
            send_text($urandom_range(0, 6));
            end_line();
        end else if (kind < 92) begin
            // plain text, sometimes indented
            if ($urandom_range(3) == 0)
                send_beat(1'b0, BLANKS[$urandom_range(1) ? 0 : 1]);
            send_text($urandom_range(0, 12));
            end_line();
        end else if (kind < 97) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 8))
                send_beat(1'b0, BYTE_W'($urandom_range(255)));
            end_line();
        end else begin
            send_beat(1'b1, BYTE_W'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int lines;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= '0;
        in_ch.end_of_input <= 1'b0;
        depth = 0;
        err   = ST_OK;
        restart_line();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script
        src_idle_pct = 30;
        for (int i = 0; i < DIR_N; i++)
            send_beat(SCRIPT[i].eoi, SCRIPT[i].chr, SCRIPT[i].typed, SCRIPT[i].want);
        drain_results();

        // random lines, idling rate re-picked every 16 lines
        lines = 0;
        while (sent < DIR_N + N_RANDOM) begin
            if (lines % 16 == 0)
                src_idle_pct = ($urandom_range(1)) ? 0 : 10 * $urandom_range(1, 5);
            send_line();
            lines++;
        end
        drain_results();

        // closing stretch, no idling from here on
        calm = 1'b1;
        while (sent < DIR_N + N_RANDOM + N_CALM)
            send_line();
        send_beat(1'b1, 8'h00);

        drain_results();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off while the sender keeps going
    // ------------------------------------------------------------------------
    initial begin : sink_ctl
        int  sink_idle_pct;
        int  budget;
        bit  held;
        sink_idle_pct = 0;
        budget        = 0;
        held          = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (budget <= 0) begin
                sink_idle_pct = ($urandom_range(1)) ? 0 : 10 * $urandom_range(1, 5);
                budget        = 64;
            end
            if (!held && !calm && results_seen >= 300) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge i_clk);
            end else if (!calm && sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) begin
                    @(posedge i_clk);
                    budget--;
                end
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
                budget--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h (output beat %0d)",
                     what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin : rx_check
        t_beat got;
        t_beat want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = '{out_ch.out_byte, out_ch.byte_valid, t_status'(out_ch.status), out_ch.last};
            results_seen++;
            if (pending_beats.size() == 0) begin
                report_mismatch("beat with nothing outstanding", 32'(got), 32'd0);
            end else begin
                want = pending_beats.pop_front();
                if (got.data !== want.data)
                    report_mismatch("out_byte", 32'(got.data), 32'(want.data));
                if (got.bvalid !== want.bvalid)
                    report_mismatch("byte_valid", 32'(got.bvalid), 32'(want.bvalid));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout with %0d beats outstanding", pending_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/core/mdle_pkg.sv
rtl/core/mdle_in_if.sv
rtl/core/mdle_out_if.sv
rtl/core/mdle_front.sv
rtl/core/mdle_queue.sv
rtl/core/mdle_back.sv
rtl/core/marker_delimited_line_extractor.sv
tb/sv/marker_delimited_line_extractor_test.sv
